// ----- src/bidirectional_flow_table_unit_defines.svh -----
// Assertion macros shared by the flow table unit.
`ifndef BIDIRECTIONAL_FLOW_TABLE_UNIT_DEFINES_SVH
`define BIDIRECTIONAL_FLOW_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define BFT_ASSERT_IMP(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("flow table: implication check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define BFT_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("flow table: next-cycle check failed");
`else
`define BFT_ASSERT_IMP(label, cond, expr)
`define BFT_ASSERT_NEXT(label, cond, expr)
`endif

`endif

// ----- src/bft_pkg.sv -----
// Types and constants shared by the flow table unit modules.
`default_nettype none

package bft_pkg;

	localparam int PROTO_W      = 8;
	localparam int IP_W         = 32;
	localparam int PORT_W       = 16;
	localparam int EP_W         = IP_W + PORT_W;
	localparam int FLOW_INDEX_W = 6;

	// One packet item.
	typedef struct packed {
		logic [PROTO_W-1:0] protocol;
		logic [IP_W-1:0]    src_ip;
		logic [PORT_W-1:0]  src_port;
		logic [IP_W-1:0]    dst_ip;
		logic [PORT_W-1:0]  dst_port;
		logic               source_is_client;
	} bft_in_t;

	// One result item.
	typedef struct packed {
		logic [FLOW_INDEX_W-1:0] flow_index;
		logic                    created;
		logic                    table_full;
		logic                    source_is_first;
		logic [IP_W-1:0]         client_ip;
		logic [PORT_W-1:0]       client_port;
		logic [IP_W-1:0]         server_ip;
		logic [PORT_W-1:0]       server_port;
	} bft_out_t;

	// One stored flow; endpoints hold the address above the port.
	typedef struct packed {
		logic [PROTO_W-1:0] protocol;
		logic [EP_W-1:0]    first_ep;
		logic [EP_W-1:0]    second_ep;
		logic               client_is_first;
	} bft_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic search_en;
		logic write_new;
		logic load_out;
	} bft_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic done;
		logic full;
		logic out_free;
	} bft_sts_t;

endpackage

`default_nettype wire

// ----- src/bidirectional_flow_table_unit.sv -----
// Top level of the bidirectional five-tuple flow table unit.
//
//   Channel  Direction  Handshake            Payload
//   pkt      in         pkt_valid/pkt_stall  bft_in_t
//   res      out        res_valid/res_stall  bft_out_t
//
// A search walks the stored entries in order through the RAM's read port, one entry per
// cycle; a hit ends the walk at the matching entry, a miss on a free table then writes
// the new flow, and a miss on a full table goes straight to loading the result.
// Reset clears the fill count and control only; entries are filled in order, so the
// entry RAM needs no clearing pass.
// A new item is taken while an earlier result waits; res_stall holds the result step.
`default_nettype none
`include "bidirectional_flow_table_unit_defines.svh"

module bidirectional_flow_table_unit
	import bft_pkg::*;
#(
	parameter int FLOW_ENTRIES = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pkt_valid,
	output logic         pkt_stall,
	input  wire bft_in_t pkt,
	output logic         res_valid,
	input  wire logic    res_stall,
	output bft_out_t     res
);

	bft_cmd_t cmd;
	bft_sts_t sts;

	bft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bft_datapath #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt      (pkt),
		.res      (res),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// An accepted item keeps the input side busy in the next cycle.
	`BFT_ASSERT_NEXT(a_busy_after_accept, pkt_valid && !pkt_stall, pkt_stall)
	// A new flow is never written into a full table.
	`BFT_ASSERT_IMP(a_no_write_when_full, cmd.write_new, !sts.full)
	// A result is loaded only when the output register is free or being emptied.
	`BFT_ASSERT_IMP(a_load_into_free_slot, cmd.load_out, sts.out_free)
	// A delivered result never claims both a created flow and a full table.
	`BFT_ASSERT_IMP(a_created_not_full, res_valid, !(res.created && res.table_full))

endmodule

`default_nettype wire

// ----- src/bft_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/bft_ctrl.sv -----
// Controller state machine for the flow table unit.
`default_nettype none

module bft_ctrl
	import bft_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pkt_valid,
	output logic          pkt_stall,
	input  wire bft_sts_t sts,
	output bft_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_WRITE  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		pkt_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				pkt_stall   = 1'b0;
				cmd.load_in = pkt_valid;
				if (pkt_valid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search_en = 1'b1;
				if (sts.hit) begin
					state_d = ST_FINISH;
				end else if (sts.done) begin
					state_d = sts.full ? ST_FINISH : ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_new = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/bft_datapath.sv -----
// Datapath of the flow table unit: key ordering, entry store, search and result.
`default_nettype none

module bft_datapath
	import bft_pkg::*;
#(
	parameter int FLOW_ENTRIES = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire bft_in_t  pkt,
	output bft_out_t      res,
	output logic          res_valid,
	input  wire logic     res_stall,
	input  wire bft_cmd_t cmd,
	output bft_sts_t      sts
);

	localparam int IDX_W = $clog2(FLOW_ENTRIES);
	localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

	logic [EP_W-1:0]  src_ep;
	logic [EP_W-1:0]  dst_ep;
	logic             swap;
	bft_entry_t       key_d;
	bft_entry_t       key_q;
	logic             src_first_q;

	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] rd_addr_q;
	logic             more;
	logic             issue;
	logic             rd_pend_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	bft_entry_t       rd_entry;
	logic             match;

	logic             found_q;
	logic             created_q;
	logic [IDX_W-1:0] found_idx_q;
	bft_entry_t       found_rec_q;
	logic             res_valid_q;
	bft_out_t         res_q;
	logic             have_flow;
	logic [EP_W-1:0]  client_ep;
	logic [EP_W-1:0]  server_ep;

	// Put the two endpoints in canonical order; equal endpoints keep the source first.
	assign src_ep = {pkt.src_ip, pkt.src_port};
	assign dst_ep = {pkt.dst_ip, pkt.dst_port};
	assign swap   = dst_ep < src_ep;

	always_comb begin
		key_d.protocol        = pkt.protocol;
		key_d.first_ep        = swap ? dst_ep : src_ep;
		key_d.second_ep       = swap ? src_ep : dst_ep;
		key_d.client_is_first = pkt.source_is_client == !swap;
	end

	// Entries fill in order, so an address below the fill count is a valid entry.
	assign more  = rd_addr_q < used_q;
	assign issue = cmd.search_en && more;
	assign match = rd_pend_s1
		&& (rd_entry.protocol == key_q.protocol)
		&& (rd_entry.first_ep == key_q.first_ep)
		&& (rd_entry.second_ep == key_q.second_ep);

	bft_ram #(
		.WIDTH($bits(bft_entry_t)),
		.DEPTH(FLOW_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (cmd.write_new),
		.waddr(used_q[IDX_W-1:0]),
		.wdata(key_q),
		.raddr(rd_addr_q[IDX_W-1:0]),
		.rdata(rd_entry)
	);

	// Status toward the controller.
	always_comb begin
		sts.hit      = match;
		sts.done     = !more && !rd_pend_s1;
		sts.full     = used_q == CNT_W'(FLOW_ENTRIES);
		sts.out_free = !res_valid_q || !res_stall;
	end

	// Control registers: fill count, read walk, outcome flags and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rd_addr_q   <= '0;
			rd_pend_s1  <= 1'b0;
			found_q     <= 1'b0;
			created_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (cmd.load_in) begin
				rd_addr_q <= '0;
				found_q   <= 1'b0;
				created_q <= 1'b0;
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + CNT_W'(1);
			end
			if (cmd.search_en && match) begin
				found_q <= 1'b1;
			end
			if (cmd.write_new) begin
				created_q <= 1'b1;
				used_q    <= used_q + CNT_W'(1);
			end
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: packet key, read index, matched or new flow.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_q       <= key_d;
			src_first_q <= !swap;
		end
		rd_idx_s1 <= rd_addr_q[IDX_W-1:0];
		if (cmd.search_en && match) begin
			found_idx_q <= rd_idx_s1;
			found_rec_q <= rd_entry;
		end else if (cmd.write_new) begin
			found_idx_q <= used_q[IDX_W-1:0];
			found_rec_q <= key_q;
		end
	end

	// Build the result; a full table gives zero index and endpoints.
	assign have_flow = found_q || created_q;
	assign client_ep = found_rec_q.client_is_first ? found_rec_q.first_ep
	                                               : found_rec_q.second_ep;
	assign server_ep = found_rec_q.client_is_first ? found_rec_q.second_ep
	                                               : found_rec_q.first_ep;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.flow_index      <= have_flow ? FLOW_INDEX_W'(found_idx_q) : '0;
			res_q.created         <= created_q;
			res_q.table_full      <= !have_flow;
			res_q.source_is_first <= src_first_q;
			res_q.client_ip       <= have_flow ? client_ep[EP_W-1:PORT_W] : '0;
			res_q.client_port     <= have_flow ? client_ep[PORT_W-1:0] : '0;
			res_q.server_ip       <= have_flow ? server_ep[EP_W-1:PORT_W] : '0;
			res_q.server_port     <= have_flow ? server_ep[PORT_W-1:0] : '0;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire
